[rtl/core/bls_pkg.sv]
package bls_pkg;

    // Coordinate arithmetic width; port fields stay 16 bits.
    localparam int COORD_BITS = 16;
    localparam int PIX_BITS   = 16;
    localparam int COLOR_BITS = 16;
    // Error term: sign plus headroom for twice the major length.
    localparam int ERR_BITS   = COORD_BITS + 3;

    typedef enum logic {
        REQ_START   = 1'b0,
        REQ_ADVANCE = 1'b1
    } t_req_type;

    typedef struct packed {
        t_req_type             req_type;
        logic [PIX_BITS-1:0]   start_x;
        logic [PIX_BITS-1:0]   start_y;
        logic [PIX_BITS-1:0]   end_x;
        logic [PIX_BITS-1:0]   end_y;
        logic [COLOR_BITS-1:0] line_color;
    } t_line_req;

    typedef struct packed {
        logic [PIX_BITS-1:0]   pixel_x;
        logic [PIX_BITS-1:0]   pixel_y;
        logic [COLOR_BITS-1:0] pixel_color;
        logic                  pixel_valid;
        logic                  last_pixel;
    } t_pixel;

endpackage

[rtl/core/bls_req_if.sv]
interface bls_req_if;
    logic              valid;
    logic              ready;
    bls_pkg::t_line_req data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

[rtl/core/bls_pix_if.sv]
interface bls_pix_if;
    logic           valid;
    logic           ready;
    bls_pkg::t_pixel data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

[rtl/core/bresenham_line_stepper.sv]
// Bresenham line stepper: a start item loads two endpoints and a color and
// returns the first pixel; each advance item returns the next pixel along the
// major axis, the final one flagged last_pixel. An advance with no line in
// progress returns an item with pixel_valid low and all fields zero, and a
// start drops any line in progress. One item is taken per clock; its result
// appears in the output register in the next cycle. The rate is set only by the
// single output register: the block stalls when that register is full and
// the sink does not take it.
module bresenham_line_stepper (
    input  logic             i_clk,
    input  logic             i_rst_n,
    bls_req_if.sink          i_req,
    bls_pix_if.source        o_pix
);

    localparam int CB = bls_pkg::COORD_BITS;
    localparam int EB = bls_pkg::ERR_BITS;
    localparam int PB = bls_pkg::PIX_BITS;

    // line state
    logic [CB-1:0]          r_cur_x, n_cur_x;
    logic [CB-1:0]          r_cur_y, n_cur_y;
    logic signed [EB-1:0]   r_err, n_err;
    logic [CB-1:0]          r_major, n_major;
    logic [CB-1:0]          r_minor, n_minor;
    logic [CB-1:0]          r_steps, n_steps;
    logic                   r_dir_x_neg, n_dir_x_neg;
    logic                   r_dir_y_neg, n_dir_y_neg;
    logic                   r_x_major, n_x_major;
    logic [bls_pkg::COLOR_BITS-1:0] r_color, n_color;
    logic                   r_busy, n_busy;

    // output register
    logic                   r_out_valid, n_out_valid;
    bls_pkg::t_pixel        r_out, n_out;

    logic                   accept;
    logic                   is_start;

    // setup from a start item
    logic [CB-1:0]          s_sx, s_sy, s_ex, s_ey;
    logic                   s_dxn, s_dyn, s_xmaj;
    logic [CB-1:0]          s_adx, s_ady, s_major, s_minor;
    logic signed [EB-1:0]   s_err;

    // working values for one step
    logic [CB-1:0]          b_x, b_y, b_major, b_minor;
    logic signed [EB-1:0]   b_err, b_err_adj;
    logic                   b_dxn, b_dyn, b_xmaj, b_last, b_minor_step;
    logic [CB-1:0]          x_step, y_step;

    assign i_req.ready = !r_out_valid || o_pix.ready;
    assign accept      = i_req.valid && i_req.ready;
    assign is_start    = i_req.data.req_type == bls_pkg::REQ_START;

    assign o_pix.valid = r_out_valid;
    assign o_pix.data  = r_out;

    always_comb begin
        s_sx    = i_req.data.start_x[CB-1:0];
        s_sy    = i_req.data.start_y[CB-1:0];
        s_ex    = i_req.data.end_x[CB-1:0];
        s_ey    = i_req.data.end_y[CB-1:0];
        s_dxn   = s_ex < s_sx;
        s_dyn   = s_ey < s_sy;
        s_adx   = s_dxn ? s_sx - s_ex : s_ex - s_sx;
        s_ady   = s_dyn ? s_sy - s_ey : s_ey - s_sy;
        s_xmaj  = s_adx >= s_ady;
        s_major = s_xmaj ? s_adx : s_ady;
        s_minor = s_xmaj ? s_ady : s_adx;
        s_err   = $signed({2'b00, s_minor, 1'b0}) - $signed({3'b000, s_major});
    end

    always_comb begin
        if (is_start) begin
            b_x     = s_sx;
            b_y     = s_sy;
            b_err   = s_err;
            b_major = s_major;
            b_minor = s_minor;
            b_dxn   = s_dxn;
            b_dyn   = s_dyn;
            b_xmaj  = s_xmaj;
            b_last  = s_major == '0;
        end else begin
            b_x     = r_cur_x;
            b_y     = r_cur_y;
            b_err   = r_err;
            b_major = r_major;
            b_minor = r_minor;
            b_dxn   = r_dir_x_neg;
            b_dyn   = r_dir_y_neg;
            b_xmaj  = r_x_major;
            b_last  = r_steps == CB'(1);
        end

        // step the minor axis when the error term is not negative
        b_minor_step = !b_err[EB-1];
        b_err_adj    = b_minor_step ? b_err - $signed({2'b00, b_major, 1'b0}) : b_err;
        x_step       = b_dxn ? b_x - CB'(1) : b_x + CB'(1);
        y_step       = b_dyn ? b_y - CB'(1) : b_y + CB'(1);
    end

    always_comb begin
        n_cur_x     = r_cur_x;
        n_cur_y     = r_cur_y;
        n_err       = r_err;
        n_major     = r_major;
        n_minor     = r_minor;
        n_steps     = r_steps;
        n_dir_x_neg = r_dir_x_neg;
        n_dir_y_neg = r_dir_y_neg;
        n_x_major   = r_x_major;
        n_color     = r_color;
        n_busy      = r_busy;
        n_out       = r_out;
        n_out_valid = r_out_valid && !o_pix.ready;

        if (accept) begin
            n_out_valid = 1'b1;
            n_out       = '0;
            if (is_start || r_busy) begin
                n_out.pixel_x     = PB'(b_x);
                n_out.pixel_y     = PB'(b_y);
                n_out.pixel_color = is_start ? i_req.data.line_color : r_color;
                n_out.pixel_valid = 1'b1;
                n_out.last_pixel  = b_last;

                n_busy      = !b_last;
                n_steps     = is_start ? s_major : r_steps - CB'(1);
                n_major     = b_major;
                n_minor     = b_minor;
                n_dir_x_neg = b_dxn;
                n_dir_y_neg = b_dyn;
                n_x_major   = b_xmaj;
                n_color     = n_out.pixel_color;
                // advance to the next pixel; unused once the line ends
                n_err       = b_err_adj + $signed({2'b00, b_minor, 1'b0});
                n_cur_x     = (b_xmaj || b_minor_step) ? x_step : b_x;
                n_cur_y     = (!b_xmaj || b_minor_step) ? y_step : b_y;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_busy      <= n_busy;
            r_out_valid <= n_out_valid;
        end
        r_cur_x     <= n_cur_x;
        r_cur_y     <= n_cur_y;
        r_err       <= n_err;
        r_major     <= n_major;
        r_minor     <= n_minor;
        r_steps     <= n_steps;
        r_dir_x_neg <= n_dir_x_neg;
        r_dir_y_neg <= n_dir_y_neg;
        r_x_major   <= n_x_major;
        r_color     <= n_color;
        r_out       <= n_out;
    end

`ifndef SYNTHESIS
    a_busy_steps: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> r_steps != '0)
        else $error("line in progress with no steps left");

    a_idle_advance: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && !is_start && !r_busy) |=> (o_pix.valid && !o_pix.data.pixel_valid))
        else $error("advance while idle gave a valid pixel");

    a_point_line: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && is_start && s_major == '0) |=> (!r_busy && o_pix.data.last_pixel))
        else $error("single-point line left the stepper busy");

    a_last_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.last_pixel) |-> r_out.pixel_valid)
        else $error("last flag on an invalid pixel");
`endif

endmodule
